@@ rtl/swpl_pkg.sv @@
package swpl_pkg;

  localparam int DefSampleBits     = 24;
  localparam int DefAmountFracBits = 16;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TARGET_AMOUNT = 2'd0,
    CFG_AMOUNT_SMOOTH = 2'd1,
    CFG_ATTACK_STEP   = 2'd2,
    CFG_RELEASE_STEP  = 2'd3
  } cfg_idx_e;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_AMT_MUL  = 12'b0000_0000_0010,
    S_AMT_UPD  = 12'b0000_0000_0100,
    S_SIDE_MUL = 12'b0000_0000_1000,
    S_SIDE     = 12'b0000_0001_0000,
    S_PEAK     = 12'b0000_0010_0000,
    S_DIV      = 12'b0000_0100_0000,
    S_GAIN     = 12'b0000_1000_0000,
    S_MUL_L    = 12'b0001_0000_0000,
    S_MUL_R    = 12'b0010_0000_0000,
    S_FIN      = 12'b0100_0000_0000,
    S_OUT      = 12'b1000_0000_0000
  } state_e;

endpackage

@@ rtl/stereo_widener_peak_limiter_core.sv @@
// Frame path: input accept, then amount update, side widening, linked peak, an optional
// restoring divide when the linked peak is over the ceiling, gain tracking, the left and
// right products and output; a frame in pass-through goes straight to the output stage.
// One frame is in work at a time; the restoring divider (one quotient bit per cycle) and
// the shared multiplier, used four times per processed frame, set the frame rate.
// Reset (async, active low): registers at their defaults, gains at unity, idle.
module stereo_widener_peak_limiter_core #(
  parameter int SAMPLE_BITS      = swpl_pkg::DefSampleBits,
  parameter int AMOUNT_FRAC_BITS = swpl_pkg::DefAmountFracBits,
  localparam int TDataW = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int CfgW   = (AMOUNT_FRAC_BITS + 1 > SAMPLE_BITS) ?
                          AMOUNT_FRAC_BITS + 1 : SAMPLE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [TDataW-1:0] s_axis_tdata,   // left_in, right_in, zero pad
  input  logic              s_axis_tlast,   // end_of_block
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [TDataW-1:0] m_axis_tdata,   // left_out, right_out, zero pad
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  localparam int SB   = SAMPLE_BITS;
  localparam int AF   = AMOUNT_FRAC_BITS;
  localparam int MaW  = (SB + 2 > AF + 2) ? SB + 2 : AF + 2;
  localparam int MbW  = (AF + 2 > SB + 1) ? AF + 2 : SB + 1;
  localparam int PW   = MaW + MbW;
  localparam int CntW = $clog2(SB);

  localparam longint OneL   = 64'sd1 <<< (SB - 1);
  localparam longint AoneL  = 64'sd1 <<< AF;
  localparam longint CeilL  = (OneL * 999 + 500) / 1000;
  localparam longint AHalfL = 64'sd1 <<< (AF - 1);
  localparam longint OHalfL = 64'sd1 <<< (SB - 2);

  localparam logic [SB-1:0] One      = SB'(OneL);
  localparam logic [AF:0]   Aone     = (AF + 1)'(AoneL);
  localparam logic [AF:0]   AIdle    = (AF + 1)'(AoneL / 100000);
  localparam logic [AF:0]   ATail    = (AF + 1)'((AoneL * 5) / 10000);
  localparam logic [SB-1:0] GIdle    = SB'(OneL - OneL / 100000);
  localparam logic [AF:0]   SmoothRst = (AF + 1)'((170 * AoneL) >>> 16);
  localparam logic [SB-1:0] AttRst   = SB'(OneL / 128);
  localparam logic [SB-1:0] RelRst   = SB'(OneL / 8192);
  localparam logic [SB:0]   CeilPk   = (SB + 1)'(CeilL);
  localparam logic [SB+1:0] CeilRem  = (SB + 2)'(CeilL);

  swpl_pkg::state_e state_q, state_d;

  logic [AF:0]   target_q, smooth_q, cur_q;
  logic [SB-1:0] attack_q, release_q, tg_q, lg_q;
  logic          active_q;
  logic          m_valid_q;

  logic signed [SB-1:0] l_q, r_q;
  logic                 eob_q;
  logic signed [SB+1:0] el_q, er_q;
  logic signed [PW-1:0] prod_q;
  logic [SB+1:0]        rem_q;
  logic [SB:0]          dvs_q;
  logic [SB-1:0]        safe_q, applied_q;
  logic [CntW-1:0]      cnt_q;
  logic [SB-1:0]        res_l_q, res_r_q, out_l_q, out_r_q;

  logic in_acc, cfg_we, bypass, out_ld;

  assign s_axis_tready = (state_q == swpl_pkg::S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == swpl_pkg::S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_we        = cfg_valid_i && cfg_ready_o;
  assign bypass        = !active_q && (target_q <= AIdle);
  assign out_ld        = (state_q == swpl_pkg::S_OUT) && (!m_valid_q || m_axis_tready);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDataW'({out_r_q, out_l_q});

  // clamp oversized registers when used
  logic [AF:0]   smooth_c;
  logic [SB-1:0] att_c, rel_c;
  assign smooth_c = (smooth_q > Aone) ? Aone : smooth_q;
  assign att_c    = (attack_q > One) ? One : attack_q;
  assign rel_c    = (release_q > One) ? One : release_q;

  // shared multiplier
  logic signed [AF+1:0] amt_diff;
  logic signed [SB:0]   lr_diff;
  logic signed [MaW-1:0] mul_a;
  logic signed [MbW-1:0] mul_b;
  logic signed [PW-1:0]  mul_p;

  assign amt_diff = $signed({1'b0, target_q}) - $signed({1'b0, cur_q});
  assign lr_diff  = $signed({l_q[SB-1], l_q}) - $signed({r_q[SB-1], r_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      swpl_pkg::S_AMT_MUL: begin
        mul_a = MaW'(amt_diff);
        mul_b = MbW'($signed({1'b0, smooth_c}));
      end
      swpl_pkg::S_SIDE_MUL: begin
        mul_a = MaW'(lr_diff);
        mul_b = MbW'($signed({1'b0, cur_q}));
      end
      swpl_pkg::S_MUL_L: begin
        mul_a = MaW'(el_q);
        mul_b = MbW'($signed({1'b0, applied_q}));
      end
      swpl_pkg::S_MUL_R: begin
        mul_a = MaW'(er_q);
        mul_b = MbW'($signed({1'b0, applied_q}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding of the registered product
  logic signed [PW-1:0] rnd_af, rnd_out, cur_sum;
  logic [AF:0]          cur_new;
  logic [SB-1:0]        sat_val;

  assign rnd_af  = (prod_q + PW'(AHalfL)) >>> AF;
  assign rnd_out = (prod_q + PW'(OHalfL)) >>> (SB - 1);
  assign cur_sum = PW'($signed({1'b0, cur_q})) + rnd_af;

  always_comb begin
    if (cur_sum < 0) begin
      cur_new = '0;
    end else if (cur_sum > PW'(AoneL)) begin
      cur_new = Aone;
    end else begin
      cur_new = cur_sum[AF:0];
    end
  end

  always_comb begin
    if (rnd_out > PW'(OneL - 1)) begin
      sat_val = SB'(OneL - 1);
    end else if (rnd_out < PW'(-OneL)) begin
      sat_val = SB'(-OneL);
    end else begin
      sat_val = rnd_out[SB-1:0];
    end
  end

  // widened samples and linked peak
  logic signed [SB+1:0] el_new, er_new;
  logic [SB:0]          abs_l, abs_r, peak;

  assign el_new = (SB + 2)'(l_q) + (SB + 2)'(rnd_af);
  assign er_new = (SB + 2)'(r_q) - (SB + 2)'(rnd_af);
  assign abs_l  = el_q[SB+1] ? (SB + 1)'(-el_q) : (SB + 1)'(el_q);
  assign abs_r  = er_q[SB+1] ? (SB + 1)'(-er_q) : (SB + 1)'(er_q);
  assign peak   = (abs_l > abs_r) ? abs_l : abs_r;

  // restoring divide step
  logic [SB+1:0] rem_sh, rem_nx;
  logic          q_bit;

  assign rem_sh = {rem_q[SB:0], 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, dvs_q});
  assign rem_nx = q_bit ? rem_sh - {1'b0, dvs_q} : rem_sh;

  // gain tracking
  logic [SB:0]          tg_sum, lg_add;
  logic signed [SB+1:0] lg_sub;
  logic [SB-1:0]        tg_new, lg_new, applied_new;

  assign tg_sum = {1'b0, tg_q} + {1'b0, rel_c};
  assign lg_add = {1'b0, lg_q} + {1'b0, rel_c};
  assign lg_sub = $signed({2'b00, lg_q}) - $signed({2'b00, att_c});

  always_comb begin
    if (safe_q < tg_q) begin
      tg_new = safe_q;
    end else if (tg_sum > {1'b0, One}) begin
      tg_new = One;
    end else begin
      tg_new = tg_sum[SB-1:0];
    end

    if (tg_new < lg_q) begin
      lg_new = (lg_sub < $signed({2'b00, tg_new})) ? tg_new : lg_sub[SB-1:0];
    end else if (tg_new > lg_q) begin
      lg_new = (lg_add > {1'b0, tg_new}) ? tg_new : lg_add[SB-1:0];
    end else begin
      lg_new = lg_q;
    end

    applied_new = (lg_new < safe_q) ? lg_new : safe_q;
  end

  // target amount write
  logic [AF:0] tgt_wr;
  logic        was_idle, eob_clear;

  assign tgt_wr    = (cfg_data_i[AF:0] > Aone) ? Aone : cfg_data_i[AF:0];
  assign was_idle  = (target_q <= AIdle) && (cur_q <= AIdle) && (lg_q >= GIdle);
  assign eob_clear = eob_q && (target_q <= AIdle) && (cur_q <= ATail) &&
                     (tg_q >= GIdle) && (lg_q >= GIdle);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      swpl_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = bypass ? swpl_pkg::S_OUT : swpl_pkg::S_AMT_MUL;
        end
      end
      swpl_pkg::S_AMT_MUL:  state_d = swpl_pkg::S_AMT_UPD;
      swpl_pkg::S_AMT_UPD:  state_d = swpl_pkg::S_SIDE_MUL;
      swpl_pkg::S_SIDE_MUL: state_d = swpl_pkg::S_SIDE;
      swpl_pkg::S_SIDE:     state_d = swpl_pkg::S_PEAK;
      swpl_pkg::S_PEAK: begin
        state_d = (peak > CeilPk) ? swpl_pkg::S_DIV : swpl_pkg::S_GAIN;
      end
      swpl_pkg::S_DIV: begin
        if (cnt_q == CntW'(SB - 2)) begin
          state_d = swpl_pkg::S_GAIN;
        end
      end
      swpl_pkg::S_GAIN:  state_d = swpl_pkg::S_MUL_L;
      swpl_pkg::S_MUL_L: state_d = swpl_pkg::S_MUL_R;
      swpl_pkg::S_MUL_R: state_d = swpl_pkg::S_FIN;
      swpl_pkg::S_FIN:   state_d = swpl_pkg::S_OUT;
      swpl_pkg::S_OUT: begin
        if (out_ld) begin
          state_d = swpl_pkg::S_IDLE;
        end
      end
      default: state_d = swpl_pkg::S_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= swpl_pkg::S_IDLE;
      target_q  <= '0;
      smooth_q  <= SmoothRst;
      attack_q  <= AttRst;
      release_q <= RelRst;
      cur_q     <= '0;
      tg_q      <= One;
      lg_q      <= One;
      active_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we) begin
        unique case (swpl_pkg::cfg_idx_e'(cfg_index_i))
          swpl_pkg::CFG_TARGET_AMOUNT: begin
            target_q <= tgt_wr;
            if (tgt_wr > AIdle) begin
              active_q <= 1'b1;
              if (was_idle) begin
                cur_q <= '0;
                tg_q  <= One;
                lg_q  <= One;
              end
            end
          end
          swpl_pkg::CFG_AMOUNT_SMOOTH: smooth_q  <= cfg_data_i[AF:0];
          swpl_pkg::CFG_ATTACK_STEP:   attack_q  <= cfg_data_i[SB-1:0];
          swpl_pkg::CFG_RELEASE_STEP:  release_q <= cfg_data_i[SB-1:0];
          default: ;
        endcase
      end

      if (state_q == swpl_pkg::S_AMT_UPD) begin
        cur_q <= cur_new;
      end
      if (state_q == swpl_pkg::S_GAIN) begin
        tg_q <= tg_new;
        lg_q <= lg_new;
      end
      // drop back to idle after a quiet block
      if ((state_q == swpl_pkg::S_FIN) && eob_clear) begin
        cur_q    <= '0;
        tg_q     <= One;
        lg_q     <= One;
        active_q <= 1'b0;
      end

      if (out_ld) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    unique case (state_q)
      swpl_pkg::S_IDLE: begin
        if (in_acc) begin
          l_q     <= s_axis_tdata[SB-1:0];
          r_q     <= s_axis_tdata[2*SB-1:SB];
          eob_q   <= s_axis_tlast;
          res_l_q <= s_axis_tdata[SB-1:0];
          res_r_q <= s_axis_tdata[2*SB-1:SB];
        end
      end
      swpl_pkg::S_SIDE: begin
        el_q <= el_new;
        er_q <= er_new;
      end
      swpl_pkg::S_PEAK: begin
        rem_q  <= CeilRem;
        dvs_q  <= peak;
        cnt_q  <= '0;
        safe_q <= (peak > CeilPk) ? '0 : One;
      end
      swpl_pkg::S_DIV: begin
        rem_q  <= rem_nx;
        safe_q <= {safe_q[SB-2:0], q_bit};
        cnt_q  <= cnt_q + 1'b1;
      end
      swpl_pkg::S_GAIN:  applied_q <= applied_new;
      swpl_pkg::S_MUL_R: res_l_q   <= sat_val;
      swpl_pkg::S_FIN:   res_r_q   <= sat_val;
      default: ;
    endcase
    if (out_ld) begin
      out_l_q <= res_l_q;
      out_r_q <= res_r_q;
    end
  end

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again while a frame is in work");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swpl_pkg::S_DIV) |-> (rem_q < {1'b0, dvs_q}))
    else $error("divider remainder not below the peak");

  a_applied_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swpl_pkg::S_MUL_L) |-> ((applied_q <= safe_q) && (applied_q <= lg_q)))
    else $error("applied gain above safe or limiter gain");

endmodule
